FILE: hw/rtl/rrz_pkg.sv
// shared types and constants of the reconnect return-to-zero block
package rrz_pkg;

    // serial divider sizes
    localparam int DIV_NW = 64;
    localparam int DIV_DW = 48;
    localparam int DIV_CW = 7;

    // serial square root sizes
    localparam int SQ_RW = 56;
    localparam int SQ_QW = 28;
    localparam int SQ_CW = 5;

    // port widths
    localparam int IN_W  = 104;
    localparam int OUT_W = 72;
    localparam int CFG_IW = 3;
    localparam int CFG_DW = 31;

    // register indexes
    localparam logic [CFG_IW-1:0] CFG_RETURN_EN  = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_SETTLE_POS = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_SETTLE_VEL = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_MAX_VEL    = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_MAX_ACC    = 3'd4;
    localparam logic [CFG_IW-1:0] CFG_PERIOD     = 3'd5;

    // register reset values
    localparam logic [30:0] RST_SETTLE_POS = 31'd1966;
    localparam logic [30:0] RST_SETTLE_VEL = 31'd13107;
    localparam logic [30:0] RST_MAX_VEL    = 31'd131072;
    localparam logic [30:0] RST_MAX_ACC    = 31'd655360;
    localparam logic [9:0]  RST_PERIOD     = 10'd10;

    // opcodes
    localparam logic [1:0] OP_UPDATE = 2'd0;
    localparam logic [1:0] OP_CANCEL = 2'd1;
    localparam logic [1:0] OP_RECONF = 2'd2;

    // stage codes
    localparam logic [1:0] STG_DISABLED = 2'd0;
    localparam logic [1:0] STG_ARMED    = 2'd1;
    localparam logic [1:0] STG_RUNNING  = 2'd2;
    localparam logic [1:0] STG_HOLDING  = 2'd3;

    // duration scale factors: 1.875 * 1000 and 5.7736 * 1000000
    localparam logic [31:0] KV_SCALE = 32'd1875;
    localparam logic [31:0] KA_SCALE = 32'd5773600;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_MUL_KV_NUM,
        ST_MUL_KV_DEN,
        ST_DIV_KV_GO,
        ST_DIV_KV_WAIT,
        ST_MUL_Q_NUM,
        ST_DIV_Q_GO,
        ST_DIV_Q_WAIT,
        ST_SQRT_GO,
        ST_SQRT_WAIT,
        ST_DIV_KA_GO,
        ST_DIV_KA_WAIT,
        ST_MUL_DUR,
        ST_SAMPLE,
        ST_DIV_T_GO,
        ST_DIV_T_WAIT,
        ST_MUL_T2,
        ST_MUL_T3,
        ST_MUL_T4,
        ST_MUL_T5,
        ST_MUL_R,
        ST_MUL_RR,
        ST_MUL_POS,
        ST_MUL_M,
        ST_DIV_V_GO,
        ST_DIV_V_WAIT,
        ST_DONE
    } state_t;

endpackage

FILE: hw/rtl/rrz_div.sv
// bit-serial restoring divider, one quotient bit per cycle
module rrz_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [rrz_pkg::DIV_NW-1:0]   num,
    input  logic [rrz_pkg::DIV_DW-1:0]   den,
    output logic                         done,
    output logic [rrz_pkg::DIV_NW-1:0]   quo,
    output logic                         rem_nz
);
    import rrz_pkg::*;

    logic              busy_reg;
    logic              done_reg;
    logic [DIV_CW-1:0] cnt_reg;
    logic [DIV_NW-1:0] quo_reg;
    logic [DIV_DW-1:0] rem_reg;
    logic [DIV_DW-1:0] den_reg;
    logic [DIV_DW:0]   rem_sh;
    logic [DIV_DW:0]   rem_diff;
    logic              ge;

    assign rem_sh   = {rem_reg, quo_reg[DIV_NW-1]};
    assign rem_diff = rem_sh - {1'b0, den_reg};
    assign ge       = rem_sh >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CW'(DIV_NW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DIV_NW-2:0], ge};
            rem_reg <= ge ? rem_diff[DIV_DW-1:0] : rem_sh[DIV_DW-1:0];
        end
    end

    assign done   = done_reg;
    assign quo    = quo_reg;
    assign rem_nz = rem_reg != '0;

endmodule

FILE: hw/rtl/rrz_sqrt.sv
// digit-serial integer square root, two radicand bits per cycle
module rrz_sqrt (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [rrz_pkg::SQ_RW-1:0]   radicand,
    output logic                        done,
    output logic [rrz_pkg::SQ_QW-1:0]   root,
    output logic                        rem_nz
);
    import rrz_pkg::*;

    logic             busy_reg;
    logic             done_reg;
    logic [SQ_CW-1:0] cnt_reg;
    logic [SQ_RW-1:0] rad_reg;
    logic [SQ_QW+1:0] rem_reg;
    logic [SQ_QW-1:0] root_reg;
    logic [SQ_QW+3:0] rem_t;
    logic [SQ_QW+3:0] trial;
    logic [SQ_QW+3:0] rem_diff;
    logic             ge;

    assign rem_t    = {rem_reg, rad_reg[SQ_RW-1 -: 2]};
    assign trial    = {2'b00, root_reg, 2'b01};
    assign rem_diff = rem_t - trial;
    assign ge       = rem_t >= trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= SQ_CW'(SQ_QW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == SQ_CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[SQ_RW-3:0], 2'b00};
            rem_reg  <= ge ? rem_diff[SQ_QW+1:0] : rem_t[SQ_QW+1:0];
            root_reg <= {root_reg[SQ_QW-2:0], ge};
        end
    end

    assign done   = done_reg;
    assign root   = root_reg;
    assign rem_nz = rem_reg != '0;

endmodule

FILE: hw/rtl/reconnect_return_to_zero.sv
// top level: reconnect return-to-zero sequencer with serial divide and square root
//
//  channel   dir  handshake                      content
//  s_axis    in   s_axis_tvalid/s_axis_tready    opcode in tuser, feedback in tdata
//  m_axis    out  m_axis_tvalid/m_axis_tready    targets, stage, active flag
//  cfg       in   cfg_we (no wait)               register index and value
//
//  an item without motion math goes straight to the result; a sample of a running move
//  takes up to two passes of the 64-step serial divider, a move start up to five passes
//  and one pass of the 28-step square root
//  reset clears flags, stage, targets and registers to their defaults, no clearing pass
//  the result sits in an output register, so a new transaction is taken while it waits
module reconnect_return_to_zero (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // now_ms[31:0], fresh[32], measured_position[64:33], measured_velocity[96:65],
    // allowed[97], zero fill above
    input  logic [rrz_pkg::IN_W-1:0]      s_axis_tdata,
    // opcode[1:0]
    input  logic [1:0]                    s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // target_position[31:0], target_velocity[63:32], stage[65:64], active[66],
    // zero fill above
    output logic [rrz_pkg::OUT_W-1:0]     m_axis_tdata,
    input  logic                          cfg_we,
    input  logic [rrz_pkg::CFG_IW-1:0]    cfg_index,
    input  logic [rrz_pkg::CFG_DW-1:0]    cfg_data
);
    import rrz_pkg::*;

    function automatic logic [31:0] mag32(input logic [31:0] x);
        mag32 = x[31] ? (32'd0 - x) : x;
    endfunction

    function automatic logic [31:0] sign_mag(input logic neg, input logic [63:0] m);
        logic [63:0] cap;
        logic [63:0] lim;
        cap = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
        lim = (m > cap) ? cap : m;
        sign_mag = neg ? (32'd0 - lim[31:0]) : lim[31:0];
    endfunction

    // configuration
    logic        en_reg;
    logic [30:0] settle_pos_reg;
    logic [30:0] settle_vel_reg;
    logic [30:0] max_vel_reg;
    logic [30:0] max_acc_reg;
    logic [9:0]  period_reg;

    // control state
    state_t      state_reg, state_next;
    logic        online_reg, online_next;
    logic        ever_reg, ever_next;
    logic        armed_reg, armed_next;
    logic        owns_reg, owns_next;
    logic [1:0]  stage_reg, stage_next;
    logic [31:0] tp_reg;
    logic [31:0] tv_reg;
    logic        out_valid_reg;
    logic [OUT_W-1:0] out_data_reg;

    // datapath
    logic [31:0] now_reg;
    logic [31:0] start_time_reg;
    logic [31:0] start_pos_reg;
    logic [31:0] dur_reg;
    logic [63:0] acc_reg;
    logic [47:0] den_reg;
    logic [31:0] kv_reg;
    logic [55:0] q_reg;
    logic [27:0] s_reg;
    logic [27:0] ka_reg;
    logic [29:0] t_reg;
    logic [29:0] t2_reg, t3_reg, t4_reg, t5_reg;
    logic [29:0] r_reg;
    logic [30:0] omb_reg;
    logic [31:0] rate_reg;
    logic [33:0] m_reg;

    // input fields
    logic [1:0]  in_op;
    logic [31:0] in_now;
    logic        in_fresh;
    logic [31:0] in_pos;
    logic [31:0] in_vel;
    logic        in_allowed;
    logic        in_fire;

    assign in_op      = s_axis_tuser;
    assign in_now     = s_axis_tdata[31:0];
    assign in_fresh   = s_axis_tdata[32];
    assign in_pos     = s_axis_tdata[64:33];
    assign in_vel     = s_axis_tdata[96:65];
    assign in_allowed = s_axis_tdata[97];
    assign in_fire    = s_axis_tvalid && s_axis_tready;

    logic [1:0]  stage_idle;
    logic [31:0] lim_vel, lim_acc;
    logic [9:0]  lim_period;
    logic [31:0] p0;
    logic        neg0;
    logic        settled_in;
    logic        start_mv;
    logic        run_sample;
    logic        tgt_clear;
    logic [31:0] elapsed;

    assign stage_idle = en_reg ? STG_ARMED : STG_DISABLED;
    assign lim_vel    = (max_vel_reg == '0) ? 32'd1 : {1'b0, max_vel_reg};
    assign lim_acc    = (max_acc_reg == '0) ? 32'd1 : {1'b0, max_acc_reg};
    assign lim_period = (period_reg == '0) ? 10'd1 : period_reg;
    assign p0         = mag32(start_pos_reg);
    assign neg0       = start_pos_reg[31];
    assign elapsed    = now_reg - start_time_reg;
    assign settled_in = (mag32(in_pos) <= {1'b0, settle_pos_reg})
                     && (mag32(in_vel) <= {1'b0, settle_vel_reg});

    // flag updates for the accepted transaction
    always_comb
    begin
        online_next = online_reg;
        ever_next   = ever_reg;
        armed_next  = armed_reg;
        owns_next   = owns_reg;
        stage_next  = stage_reg;
        start_mv    = 1'b0;
        run_sample  = 1'b0;
        tgt_clear   = 1'b0;
        unique case (in_op)
            OP_UPDATE:
            begin
                if (!in_fresh)
                begin
                    if (online_reg || owns_reg)
                    begin
                        online_next = 1'b0;
                        armed_next  = en_reg && in_allowed && ever_reg;
                        owns_next   = 1'b0;
                    end
                    stage_next = stage_idle;
                end
                else
                begin
                    online_next = 1'b1;
                    if (!ever_reg)
                    begin
                        ever_next  = 1'b1;
                        armed_next = 1'b0;
                        owns_next  = 1'b0;
                        stage_next = stage_idle;
                    end
                    else if (!en_reg || !in_allowed)
                    begin
                        armed_next = 1'b0;
                        owns_next  = 1'b0;
                        stage_next = stage_idle;
                    end
                    else
                    begin
                        if (!online_reg && armed_reg && !owns_reg)
                        begin
                            start_mv   = 1'b1;
                            armed_next = 1'b0;
                            owns_next  = 1'b1;
                            stage_next = STG_RUNNING;
                        end
                        if (owns_next)
                        begin
                            if (settled_in)
                            begin
                                stage_next = STG_HOLDING;
                                tgt_clear  = 1'b1;
                            end
                            else if (stage_next == STG_RUNNING)
                            begin
                                run_sample = 1'b1;
                            end
                        end
                    end
                end
            end
            OP_CANCEL:
            begin
                armed_next = 1'b0;
                owns_next  = 1'b0;
                tgt_clear  = 1'b1;
                stage_next = stage_idle;
            end
            OP_RECONF:
            begin
                online_next = in_fresh;
                armed_next  = en_reg && ever_reg && !in_fresh;
                owns_next   = 1'b0;
                tgt_clear   = 1'b1;
                stage_next  = stage_idle;
            end
            default:
            begin
                online_next = online_reg;
            end
        endcase
    end

    // serial units and shared multiplier
    logic                div_start, div_done, div_rem_nz;
    logic [DIV_NW-1:0]   div_num, div_quo;
    logic [DIV_DW-1:0]   div_den;
    logic                sq_start, sq_done, sq_rem_nz;
    logic [SQ_QW-1:0]    sq_root;
    logic [31:0]         mul_a, mul_b;
    logic [63:0]         prod;
    logic [63:0]         m1000;
    logic [63:0]         div_ceil;
    logic [31:0]         k_sel;

    assign prod     = mul_a * mul_b;
    assign m1000    = ({30'd0, m_reg} << 10) - ({30'd0, m_reg} << 4) - ({30'd0, m_reg} << 3);
    assign div_ceil = div_quo + {63'd0, div_rem_nz};

    always_comb
    begin
        k_sel = (kv_reg > {4'd0, ka_reg}) ? kv_reg : {4'd0, ka_reg};
        if (k_sel == '0)
        begin
            k_sel = 32'd1;
        end
    end

    rrz_div u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .num    (div_num),
        .den    (div_den),
        .done   (div_done),
        .quo    (div_quo),
        .rem_nz (div_rem_nz)
    );

    rrz_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (q_reg),
        .done     (sq_done),
        .root     (sq_root),
        .rem_nz   (sq_rem_nz)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (!run_sample)
                        state_next = ST_DONE;
                    else if (start_mv && (mag32(in_pos) > {1'b0, settle_pos_reg}))
                        state_next = ST_MUL_KV_NUM;
                    else
                        state_next = ST_SAMPLE;
                end
            end
            ST_MUL_KV_NUM:  state_next = ST_MUL_KV_DEN;
            ST_MUL_KV_DEN:  state_next = ST_DIV_KV_GO;
            ST_DIV_KV_GO:   state_next = ST_DIV_KV_WAIT;
            ST_DIV_KV_WAIT: if (div_done) state_next = ST_MUL_Q_NUM;
            ST_MUL_Q_NUM:   state_next = ST_DIV_Q_GO;
            ST_DIV_Q_GO:    state_next = ST_DIV_Q_WAIT;
            ST_DIV_Q_WAIT:  if (div_done) state_next = ST_SQRT_GO;
            ST_SQRT_GO:     state_next = ST_SQRT_WAIT;
            ST_SQRT_WAIT:   if (sq_done) state_next = ST_DIV_KA_GO;
            ST_DIV_KA_GO:   state_next = ST_DIV_KA_WAIT;
            ST_DIV_KA_WAIT: if (div_done) state_next = ST_MUL_DUR;
            ST_MUL_DUR:     state_next = ST_SAMPLE;
            ST_SAMPLE:
            begin
                if ((dur_reg == '0) || (elapsed >= dur_reg))
                    state_next = ST_DONE;
                else
                    state_next = ST_DIV_T_GO;
            end
            ST_DIV_T_GO:    state_next = ST_DIV_T_WAIT;
            ST_DIV_T_WAIT:  if (div_done) state_next = ST_MUL_T2;
            ST_MUL_T2:      state_next = ST_MUL_T3;
            ST_MUL_T3:      state_next = ST_MUL_T4;
            ST_MUL_T4:      state_next = ST_MUL_T5;
            ST_MUL_T5:      state_next = ST_MUL_R;
            ST_MUL_R:       state_next = ST_MUL_RR;
            ST_MUL_RR:      state_next = ST_MUL_POS;
            ST_MUL_POS:     state_next = ST_MUL_M;
            ST_MUL_M:       state_next = ST_DIV_V_GO;
            ST_DIV_V_GO:    state_next = ST_DIV_V_WAIT;
            ST_DIV_V_WAIT:  if (div_done) state_next = ST_DONE;
            ST_DONE:        if (!out_valid_reg || m_axis_tready) state_next = ST_IDLE;
            default:        state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        s_axis_tready = 1'b0;
        div_start     = 1'b0;
        sq_start      = 1'b0;
        div_num       = '0;
        div_den       = '0;
        mul_a         = '0;
        mul_b         = '0;
        unique case (state_reg)
            ST_IDLE:       s_axis_tready = 1'b1;
            ST_MUL_KV_NUM:
            begin
                mul_a = KV_SCALE;
                mul_b = p0;
            end
            ST_MUL_KV_DEN:
            begin
                mul_a = lim_vel;
                mul_b = {22'd0, lim_period};
            end
            ST_DIV_KV_GO:
            begin
                div_start = 1'b1;
                div_num   = acc_reg;
                div_den   = den_reg;
            end
            ST_MUL_Q_NUM:
            begin
                mul_a = KA_SCALE;
                mul_b = p0;
            end
            ST_DIV_Q_GO:
            begin
                div_start = 1'b1;
                div_num   = acc_reg;
                div_den   = {16'd0, lim_acc};
            end
            ST_SQRT_GO:    sq_start = 1'b1;
            ST_DIV_KA_GO:
            begin
                div_start = 1'b1;
                div_num   = {36'd0, s_reg};
                div_den   = {38'd0, lim_period};
            end
            ST_MUL_DUR:
            begin
                mul_a = k_sel;
                mul_b = {22'd0, lim_period};
            end
            ST_DIV_T_GO:
            begin
                div_start = 1'b1;
                div_num   = {2'b00, elapsed, 30'd0};
                div_den   = {16'd0, dur_reg};
            end
            ST_MUL_T2:
            begin
                mul_a = {2'b00, t_reg};
                mul_b = {2'b00, t_reg};
            end
            ST_MUL_T3:
            begin
                mul_a = {2'b00, t2_reg};
                mul_b = {2'b00, t_reg};
            end
            ST_MUL_T4:
            begin
                mul_a = {2'b00, t3_reg};
                mul_b = {2'b00, t_reg};
            end
            ST_MUL_T5:
            begin
                mul_a = {2'b00, t4_reg};
                mul_b = {2'b00, t_reg};
            end
            ST_MUL_R:
            begin
                mul_a = {2'b00, t_reg};
                mul_b = 32'h4000_0000 - {2'b00, t_reg};
            end
            ST_MUL_RR:
            begin
                mul_a = {2'b00, r_reg};
                mul_b = {2'b00, r_reg};
            end
            ST_MUL_POS:
            begin
                mul_a = p0;
                mul_b = {1'b0, omb_reg};
            end
            ST_MUL_M:
            begin
                mul_a = p0;
                mul_b = rate_reg;
            end
            ST_DIV_V_GO:
            begin
                div_start = 1'b1;
                div_num   = m1000;
                div_den   = {16'd0, dur_reg};
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    // blend = 10t^3 - 15t^4 + 6t^5, clamped to [0, 1]
    logic signed [35:0] blend_raw;
    logic        [30:0] blend_clamp;

    always_comb
    begin
        blend_raw = $signed({6'd0, t3_reg}) * 36'sd10
                  - $signed({6'd0, t4_reg}) * 36'sd15
                  + $signed({6'd0, t5_reg}) * 36'sd6;
        if (blend_raw < 0)
            blend_clamp = '0;
        else if (blend_raw > 36'sh0_4000_0000)
            blend_clamp = 31'h4000_0000;
        else
            blend_clamp = blend_raw[30:0];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_reg         <= 1'b0;
            settle_pos_reg <= RST_SETTLE_POS;
            settle_vel_reg <= RST_SETTLE_VEL;
            max_vel_reg    <= RST_MAX_VEL;
            max_acc_reg    <= RST_MAX_ACC;
            period_reg     <= RST_PERIOD;
            state_reg      <= ST_IDLE;
            online_reg     <= 1'b0;
            ever_reg       <= 1'b0;
            armed_reg      <= 1'b0;
            owns_reg       <= 1'b0;
            stage_reg      <= STG_DISABLED;
            tp_reg         <= '0;
            tv_reg         <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_RETURN_EN:  en_reg         <= cfg_data[0];
                    CFG_SETTLE_POS: settle_pos_reg <= cfg_data;
                    CFG_SETTLE_VEL: settle_vel_reg <= cfg_data;
                    CFG_MAX_VEL:    max_vel_reg    <= cfg_data;
                    CFG_MAX_ACC:    max_acc_reg    <= cfg_data;
                    CFG_PERIOD:     period_reg     <= cfg_data[9:0];
                    default:        en_reg         <= en_reg;
                endcase
            end
            state_reg <= state_next;
            if (in_fire)
            begin
                online_reg <= online_next;
                ever_reg   <= ever_next;
                armed_reg  <= armed_next;
                owns_reg   <= owns_next;
                stage_reg  <= stage_next;
                if (tgt_clear)
                begin
                    tp_reg <= '0;
                    tv_reg <= '0;
                end
            end
            if ((state_reg == ST_SAMPLE) && (state_next == ST_DONE))
            begin
                tp_reg <= '0;
                tv_reg <= '0;
            end
            if (state_reg == ST_MUL_POS)
                tp_reg <= sign_mag(neg0, {30'd0, prod[63:30]});
            if ((state_reg == ST_DIV_V_WAIT) && div_done)
                tv_reg <= sign_mag(!neg0, div_quo);
            if ((state_reg == ST_DONE) && (!out_valid_reg || m_axis_tready))
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            now_reg <= in_now;
            if (start_mv)
            begin
                start_time_reg <= in_now;
                start_pos_reg  <= in_pos;
                dur_reg        <= '0;
            end
        end
        if ((state_reg == ST_DONE) && (!out_valid_reg || m_axis_tready))
            out_data_reg <= {5'd0, owns_reg, stage_reg, tv_reg, tp_reg};
        unique case (state_reg)
            ST_MUL_KV_NUM:  acc_reg <= prod;
            ST_MUL_KV_DEN:  den_reg <= prod[47:0];
            ST_DIV_KV_WAIT:
            begin
                if (div_done)
                    kv_reg <= (div_ceil > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : div_ceil[31:0];
            end
            ST_MUL_Q_NUM:   acc_reg <= prod;
            ST_DIV_Q_WAIT:  if (div_done) q_reg <= div_ceil[55:0];
            ST_SQRT_WAIT:   if (sq_done) s_reg <= sq_root + {27'd0, sq_rem_nz};
            ST_DIV_KA_WAIT: if (div_done) ka_reg <= div_ceil[27:0];
            ST_MUL_DUR:
                dur_reg <= (prod > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : prod[31:0];
            ST_DIV_T_WAIT:  if (div_done) t_reg <= div_quo[29:0];
            ST_MUL_T2:      t2_reg <= prod[59:30];
            ST_MUL_T3:      t3_reg <= prod[59:30];
            ST_MUL_T4:      t4_reg <= prod[59:30];
            ST_MUL_T5:      t5_reg <= prod[59:30];
            ST_MUL_R:
            begin
                r_reg   <= prod[59:30];
                omb_reg <= 31'h4000_0000 - blend_clamp;
            end
            // rate = 30 * trunc(r * r)
            ST_MUL_RR:      rate_reg <= ({2'b00, prod[59:30]} << 5) - ({2'b00, prod[59:30]} << 1);
            ST_MUL_M:       m_reg <= prod[63:30];
            default:        acc_reg <= acc_reg;
        endcase
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

FILE: bench/rrz_checker.sv
// return-to-zero predictor and result checker for the stream channels
`timescale 1ns / 100ps

module rrz_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_axis_tvalid,
    input  logic                         s_axis_tready,
    input  logic [rrz_pkg::IN_W-1:0]     s_axis_tdata,
    input  logic [1:0]                   s_axis_tuser,
    input  logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    input  logic [rrz_pkg::OUT_W-1:0]    m_axis_tdata,
    input  logic                         cfg_we,
    input  logic [rrz_pkg::CFG_IW-1:0]   cfg_index,
    input  logic [rrz_pkg::CFG_DW-1:0]   cfg_data,
    output int                           errors,
    output int                           pending
);
    import rrz_pkg::*;

    localparam logic [63:0] Q30 = 64'd1 << 30;

    typedef struct packed {
        logic [31:0] tpos;
        logic [31:0] tvel;
        logic [1:0]  stage;
        logic        active;
    } target_t;

    target_t targets_q[$];

    // register copies
    logic        ret_en;
    logic [30:0] set_pos, set_vel, vmax, amax;
    logic [9:0]  per;

    // tracking state
    logic        online, ever_up, armed, owning;
    logic [1:0]  stage_r;
    logic [31:0] t0, p_start, dur, tpos_r, tvel_r;

    function automatic logic [63:0] mag(input logic [31:0] x);
        return x[31] ? (64'd1 << 32) - {32'd0, x} : {32'd0, x};
    endfunction

    function automatic logic [31:0] signed_sat(input logic neg, input logic [63:0] m);
        logic [63:0] cap;
        cap = neg ? (64'd1 << 31) : ((64'd1 << 31) - 1);
        if (m > cap)
            m = cap;
        return neg ? 32'd0 - m[31:0] : m[31:0];
    endfunction

    function automatic logic [63:0] sqrt_up(input logic [63:0] q);
        logic [63:0] r, c;
        r = 0;
        for (int i = 31; i >= 0; i--)
        begin
            c = r | (64'd1 << i);
            if (c * c <= q)
                r = c;
        end
        if (r * r < q)
            r = r + 1;
        return r;
    endfunction

    function automatic logic [31:0] move_time(input logic [63:0] d);
        logic [63:0] p, vm, am, kv, ka, k, q, total;
        p  = (per == 0) ? 64'd1 : {54'd0, per};
        vm = (vmax == 0) ? 64'd1 : {33'd0, vmax};
        am = (amax == 0) ? 64'd1 : {33'd0, amax};
        if (d <= {33'd0, set_pos})
            return 32'd0;
        kv = (64'd1875 * d + vm * p - 1) / (vm * p);
        q  = (64'd5773600 * d + am - 1) / am;
        ka = (sqrt_up(q) + p - 1) / p;
        k  = (kv > ka) ? kv : ka;
        if (k < 1)
            k = 1;
        total = k * p;
        return (total > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : total[31:0];
    endfunction

    function automatic logic inside_window(input logic [31:0] p, input logic [31:0] v);
        return mag(p) <= {33'd0, set_pos} && mag(v) <= {33'd0, set_vel};
    endfunction

    task automatic blend_targets(input logic [31:0] now);
        logic [31:0] e;
        logic [63:0] dd, t, t2, t3, t4, t5, r, rate, p0, m;
        longint      bl;
        e  = now - t0;
        dd = {32'd0, dur};
        if (dd == 0 || {32'd0, e} >= dd)
        begin
            tpos_r = 0;
            tvel_r = 0;
            return;
        end
        t  = ({32'd0, e} << 30) / dd;
        t2 = (t * t) >> 30;
        t3 = (t2 * t) >> 30;
        t4 = (t3 * t) >> 30;
        t5 = (t4 * t) >> 30;
        bl = 10 * longint'(t3) - 15 * longint'(t4) + 6 * longint'(t5);
        if (bl < 0)
            bl = 0;
        if (bl > longint'(Q30))
            bl = longint'(Q30);
        r    = (t * (Q30 - t)) >> 30;
        rate = 30 * ((r * r) >> 30);
        p0   = mag(p_start);
        tpos_r = signed_sat(p_start[31], (p0 * (Q30 - 64'(bl))) >> 30);
        m      = (p0 * rate) >> 30;
        tvel_r = signed_sat(!p_start[31], (m * 1000) / dd);
    endtask

    task automatic feedback(input logic [31:0] now, input logic fr, input logic [31:0] pos,
                            input logic [31:0] vel, input logic ok);
        logic was;
        if (!fr)
        begin
            if (online || owning)
            begin
                online = 0;
                armed  = ret_en && ok && ever_up;
                owning = 0;
            end
            stage_r = ret_en ? STG_ARMED : STG_DISABLED;
            return;
        end
        was    = online;
        online = 1;
        if (!ever_up)
        begin
            ever_up = 1;
            armed   = 0;
            owning  = 0;
            stage_r = ret_en ? STG_ARMED : STG_DISABLED;
            return;
        end
        if (!ret_en || !ok)
        begin
            armed   = 0;
            owning  = 0;
            stage_r = ret_en ? STG_ARMED : STG_DISABLED;
            return;
        end
        // reconnect after a dropout starts the move
        if (!was && armed && !owning)
        begin
            armed   = 0;
            owning  = 1;
            t0      = now;
            p_start = pos;
            dur     = move_time(mag(pos));
            tpos_r  = pos;
            tvel_r  = 0;
            if (inside_window(pos, vel))
            begin
                stage_r = STG_HOLDING;
                tpos_r  = 0;
            end
            else
                stage_r = STG_RUNNING;
        end
        if (!owning)
            return;
        if (inside_window(pos, vel))
        begin
            stage_r = STG_HOLDING;
            tpos_r  = 0;
            tvel_r  = 0;
            return;
        end
        if (stage_r == STG_RUNNING)
            blend_targets(now);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ret_en  = 0;
            set_pos = RST_SETTLE_POS;
            set_vel = RST_SETTLE_VEL;
            vmax    = RST_MAX_VEL;
            amax    = RST_MAX_ACC;
            per     = RST_PERIOD;
            online  = 0;
            ever_up = 0;
            armed   = 0;
            owning  = 0;
            stage_r = STG_DISABLED;
            t0      = 0;
            p_start = 0;
            dur     = 0;
            tpos_r  = 0;
            tvel_r  = 0;
            errors  <= 0;
            pending <= 0;
            targets_q.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_RETURN_EN:  ret_en = cfg_data[0];
                    CFG_SETTLE_POS: set_pos = cfg_data;
                    CFG_SETTLE_VEL: set_vel = cfg_data;
                    CFG_MAX_VEL:    vmax = cfg_data;
                    CFG_MAX_ACC:    amax = cfg_data;
                    CFG_PERIOD:     per = cfg_data[9:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                case (s_axis_tuser)
                    OP_UPDATE:
                        feedback(s_axis_tdata[31:0], s_axis_tdata[32], s_axis_tdata[64:33],
                                 s_axis_tdata[96:65], s_axis_tdata[97]);
                    OP_CANCEL:
                    begin
                        armed   = 0;
                        owning  = 0;
                        tpos_r  = 0;
                        tvel_r  = 0;
                        stage_r = ret_en ? STG_ARMED : STG_DISABLED;
                    end
                    OP_RECONF:
                    begin
                        online  = s_axis_tdata[32];
                        armed   = ret_en && ever_up && !s_axis_tdata[32];
                        owning  = 0;
                        tpos_r  = 0;
                        tvel_r  = 0;
                        stage_r = ret_en ? STG_ARMED : STG_DISABLED;
                    end
                    default: ;
                endcase
                targets_q.push_back('{tpos_r, tvel_r, stage_r, owning});
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                target_t exp_t;
                int      bad;
                bad = 0;
                if (targets_q.size() == 0)
                begin
                    $error("transaction with no result expected: %h", m_axis_tdata);
                    bad = 1;
                end
                else
                begin
                    exp_t = targets_q.pop_front();
                    if (m_axis_tdata[31:0] !== exp_t.tpos)
                    begin
                        $error("target_position expected %h got %h", exp_t.tpos,
                               m_axis_tdata[31:0]);
                        bad++;
                    end
                    if (m_axis_tdata[63:32] !== exp_t.tvel)
                    begin
                        $error("target_velocity expected %h got %h", exp_t.tvel,
                               m_axis_tdata[63:32]);
                        bad++;
                    end
                    if (m_axis_tdata[65:64] !== exp_t.stage)
                    begin
                        $error("stage expected %0d got %0d", exp_t.stage,
                               m_axis_tdata[65:64]);
                        bad++;
                    end
                    if (m_axis_tdata[66] !== exp_t.active)
                    begin
                        $error("active expected %0d got %0d", exp_t.active, m_axis_tdata[66]);
                        bad++;
                    end
                end
                errors <= errors + bad;
            end
            pending <= targets_q.size();
        end
    end

endmodule

FILE: bench/tb_reconnect_return_to_zero.sv
// stimulus, register settings and verdict for the return-to-zero block
`timescale 1ns / 100ps

module tb_reconnect_return_to_zero;
    import rrz_pkg::*;

    localparam logic [1:0] OP_NONE = 2'd3;

    logic               clk = 0;
    logic               rst_n = 0;
    logic               s_axis_tvalid = 0;
    logic               s_axis_tready;
    // now_ms, fresh, measured_position, measured_velocity, allowed, zero fill
    logic [IN_W-1:0]    s_axis_tdata = '0;
    // opcode
    logic [1:0]         s_axis_tuser = OP_UPDATE;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 0;
    // target_position, target_velocity, stage, active, zero fill
    logic [OUT_W-1:0]   m_axis_tdata;
    logic               cfg_we = 0;
    logic [CFG_IW-1:0]  cfg_index = CFG_RETURN_EN;
    logic [CFG_DW-1:0]  cfg_data = '0;
    int                 errors, pending;
    int                 gap_pct = 0, stall_pct = 0;
    logic [31:0]        clock_ms = 0;

    always #5 clk = ~clk;

    reconnect_return_to_zero u_dut (.*);

    rrz_checker u_chk (.*);

    always @(negedge clk)
        m_axis_tready <= ($urandom_range(99) >= stall_pct);

    initial
    begin
        #50_000_000;
        $display("tb_reconnect_return_to_zero failed");
        $finish;
    end

    task automatic send(input logic [1:0] op, input logic [31:0] now, input logic fr,
                        input logic [31:0] pos, input logic [31:0] vel, input logic ok);
        @(negedge clk);
        while ($urandom_range(99) < gap_pct)
        begin
            s_axis_tvalid = 0;
            @(negedge clk);
        end
        s_axis_tvalid = 1;
        s_axis_tuser  = op;
        s_axis_tdata  = {6'd0, ok, vel, pos, fr, now};
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic feed(input logic fr, input logic [31:0] pos, input logic [31:0] vel,
                        input logic ok);
        clock_ms = clock_ms + $urandom_range(0, 300);
        send(OP_UPDATE, clock_ms, fr, pos, vel, ok);
    endtask

    task automatic settle_down();
        @(negedge clk);
        s_axis_tvalid = 0;
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] val);
        @(negedge clk);
        cfg_we    = 1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_we = 0;
    endtask

    function automatic logic [31:0] rnd_pos();
        case ($urandom_range(3))
            0: return $urandom_range(0, 4000) - 2000;
            1: return $urandom_range(0, 1 << 20) - (1 << 19);
            default: return $urandom;
        endcase
    endfunction

    // dropout then reconnect, followed by feedback through the move
    task automatic reconnect_run();
        logic [31:0] p0;
        int          n;
        p0 = rnd_pos();
        feed(1, $urandom, $urandom, 1);
        feed(0, $urandom, $urandom, $urandom_range(9) != 0);
        feed(1, p0, $urandom, $urandom_range(9) != 0);
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++)
            feed($urandom_range(19) != 0, ($urandom_range(7) == 0) ? 32'd0 : $urandom,
                 ($urandom_range(7) == 0) ? 32'd0 : $urandom, $urandom_range(19) != 0);
    endtask

    task automatic noise_item();
        case ($urandom_range(5))
            0: send(OP_CANCEL, $urandom, $urandom, $urandom, $urandom, $urandom);
            1: send(OP_RECONF, $urandom, $urandom, $urandom, $urandom, $urandom);
            2: send(OP_NONE, $urandom, $urandom, $urandom, $urandom, $urandom);
            default: send(OP_UPDATE, $urandom, $urandom, $urandom, $urandom, $urandom);
        endcase
    endtask

    task automatic load_regs(input int sel);
        case (sel)
            0:
            begin
                write_reg(CFG_RETURN_EN, 1);
            end
            1:
            begin
                write_reg(CFG_SETTLE_POS, 0);
                write_reg(CFG_SETTLE_VEL, 0);
                write_reg(CFG_PERIOD, 1);
            end
            2:
            begin
                // fast move limits: velocity saturates
                write_reg(CFG_MAX_VEL, 31'h7FFF_FFFF);
                write_reg(CFG_MAX_ACC, 31'h7FFF_FFFF);
                write_reg(CFG_PERIOD, 0);
            end
            3:
            begin
                // slow move limits: duration saturates
                write_reg(CFG_MAX_VEL, 1);
                write_reg(CFG_MAX_ACC, 1);
                write_reg(CFG_PERIOD, 1000);
            end
            4:
            begin
                write_reg(CFG_MAX_VEL, 0);
                write_reg(CFG_MAX_ACC, 0);
                write_reg(CFG_SETTLE_POS, 31'h7FFF_FFFF);
                write_reg(CFG_SETTLE_VEL, 31'h7FFF_FFFF);
            end
            5:
            begin
                write_reg(CFG_RETURN_EN, 1);
                write_reg(CFG_SETTLE_POS, $urandom_range(0, 70000));
                write_reg(CFG_SETTLE_VEL, $urandom_range(0, 70000));
                write_reg(CFG_MAX_VEL, $urandom_range(1 << 12, 1 << 20));
                write_reg(CFG_MAX_ACC, $urandom_range(1 << 14, 1 << 22));
                write_reg(CFG_PERIOD, $urandom_range(1, 50));
            end
            default:
            begin
                write_reg(CFG_RETURN_EN, 0);
                write_reg(CFG_SETTLE_POS, RST_SETTLE_POS);
                write_reg(CFG_SETTLE_VEL, RST_SETTLE_VEL);
                write_reg(CFG_MAX_VEL, RST_MAX_VEL);
                write_reg(CFG_MAX_ACC, RST_MAX_ACC);
                write_reg(CFG_PERIOD, RST_PERIOD);
            end
        endcase
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed: first contact, disabled stage, extremes, all opcodes
        send(OP_UPDATE, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF, 1);
        send(OP_UPDATE, 32'hFFFF_FFFF, 1, 32'h7FFF_FFFF, 32'h8000_0000, 1);
        send(OP_NONE, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1);
        send(OP_CANCEL, 0, 1, 0, 0, 0);
        send(OP_RECONF, 0, 0, 0, 0, 0);
        settle_down();
        write_reg(CFG_RETURN_EN, 1);
        send(OP_UPDATE, 100, 1, 0, 0, 1);
        send(OP_UPDATE, 110, 0, 5, 5, 1);
        send(OP_UPDATE, 120, 1, 32'h8000_0000, 32'h7FFF_FFFF, 1);
        send(OP_UPDATE, 500, 1, 32'h7FFF_FFFF, 32'h8000_0000, 1);
        send(OP_UPDATE, 900, 0, 32'h1234_5678, 0, 1);  // dropout keeps targets
        send(OP_UPDATE, 1000, 1, 32'h0001_0000, 32'h0001_0000, 1);
        send(OP_UPDATE, 1200, 1, 0, 0, 1);             // settled, holding
        send(OP_RECONF, 1300, 0, 0, 0, 1);
        send(OP_UPDATE, 1400, 1, 32'h0004_0000, 0, 1);
        send(OP_UPDATE, 32'h0000_0010, 1, 32'h0004_0000, 0, 1);  // tick wrap
        send(OP_CANCEL, 0, 1, 0, 0, 1);
        send(OP_UPDATE, 0, 1, 32'h7FFF_FFFF, 0, 0);
        settle_down();

        for (int set = 0; set < 7; set++)
        begin
            load_regs(set);
            for (int ph = 0; ph < 4; ph++)
            begin
                gap_pct   = (ph == 1 || ph == 3) ? ((ph == 3) ? 16 : 54) : 0;
                stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 16 : 54) : 0;
                for (int k = 0; k < 3; k++)
                begin
                    reconnect_run();
                    if ($urandom_range(3) == 0)
                        noise_item();
                end
            end
            settle_down();
        end
        gap_pct   = 0;
        stall_pct = 0;
        settle_down();

        if (errors == 0 && pending == 0)
            $display("tb_reconnect_return_to_zero passed");
        else
        begin
            if (pending != 0)
                $error("results never delivered: %0d", pending);
            $display("tb_reconnect_return_to_zero failed");
        end
        $finish;
    end

endmodule
